[rtl/mflrd_pkg.sv]
package mflrd_pkg;

  // operation codes carried in s_tuser
  localparam logic [2:0] OP_POINT = 3'd0;
  localparam logic [2:0] OP_LINE  = 3'd1;
  localparam logic [2:0] OP_RECT  = 3'd2;
  localparam logic [2:0] OP_FILL  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // endpoint sources for the line engine
  localparam logic [2:0] SRC_POINT  = 3'd0;
  localparam logic [2:0] SRC_FULL   = 3'd1;
  localparam logic [2:0] SRC_EDGE0  = 3'd2;  // (sx,sy)-(sx,ey)
  localparam logic [2:0] SRC_EDGE1  = 3'd3;  // (sx,sy)-(ex,sy)
  localparam logic [2:0] SRC_EDGE2  = 3'd4;  // (sx,ey)-(ex,ey)
  localparam logic [2:0] SRC_EDGE3  = 3'd5;  // (ex,sy)-(ex,ey)
  localparam logic [2:0] SRC_COLUMN = 3'd6;  // one fill column

  localparam logic [7:0] PIX_MASK = 8'h80;

  localparam int COORD_W = 15;
  localparam int CUR_W   = 17;

  typedef struct packed {
    logic       clr;
    logic       capture;
    logic       line_ld;
    logic [2:0] src;
    logic       px_addr;
    logic       px_rd;
    logic       px_wr;
    logic       fill_init;
    logic       fill_next;
    logic       rd_issue;
    logic       rd_take;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       clr_last;
    logic       run_done;
    logic       fill_empty;
    logic       fill_last;
    logic       out_free;
  } sts_t;

endpackage

[rtl/mflrd_ram.sv]
module mflrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mflrd_ctrl.sv]
module mflrd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  mflrd_pkg::sts_t sts,
  output mflrd_pkg::cmd_t cmd
);
  import mflrd_pkg::*;

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_DISPATCH  = 4'd2;
  localparam logic [3:0] S_LINE_LD   = 4'd3;
  localparam logic [3:0] S_PX_ADDR   = 4'd4;
  localparam logic [3:0] S_PX_RD     = 4'd5;
  localparam logic [3:0] S_PX_WR     = 4'd6;
  localparam logic [3:0] S_FILL_INIT = 4'd7;
  localparam logic [3:0] S_FILL_CHK  = 4'd8;
  localparam logic [3:0] S_RD_ISSUE  = 4'd9;
  localparam logic [3:0] S_RD_DATA   = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  logic [3:0] state, state_next;
  logic [2:0] src, src_next;
  logic [1:0] edge_phase, edge_phase_next;

  function automatic logic [2:0] edge_src(input logic [1:0] e);
    logic [2:0] s;
    unique case (e)
      2'd0: s = SRC_EDGE0;
      2'd1: s = SRC_EDGE1;
      2'd2: s = SRC_EDGE2;
      default: s = SRC_EDGE3;
    endcase
    return s;
  endfunction

  assign s_tready = (state == S_IDLE);

  // next state and command decode
  always_comb begin
    state_next      = state;
    src_next        = src;
    edge_phase_next = edge_phase;
    cmd             = '0;
    cmd.src         = src;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        edge_phase_next = 2'd0;
        case (sts.op)
          OP_POINT: begin
            src_next   = SRC_POINT;
            state_next = S_LINE_LD;
          end
          OP_LINE: begin
            src_next   = SRC_FULL;
            state_next = S_LINE_LD;
          end
          OP_RECT: begin
            src_next   = SRC_EDGE0;
            state_next = S_LINE_LD;
          end
          OP_FILL: state_next = S_FILL_INIT;
          OP_READ: state_next = S_RD_ISSUE;
          default: state_next = S_DONE;
        endcase
      end
      S_LINE_LD: begin
        cmd.line_ld = 1'b1;
        state_next  = S_PX_ADDR;
      end
      S_PX_ADDR: begin
        cmd.px_addr = 1'b1;
        state_next  = S_PX_RD;
      end
      S_PX_RD: begin
        cmd.px_rd  = 1'b1;
        state_next = S_PX_WR;
      end
      S_PX_WR: begin
        cmd.px_wr = 1'b1;
        if (!sts.run_done) begin
          state_next = S_PX_ADDR;
        end else if (sts.op == OP_RECT && edge_phase != 2'd3) begin
          edge_phase_next = edge_phase + 2'd1;
          src_next        = edge_src(edge_phase + 2'd1);
          state_next      = S_LINE_LD;
        end else if (sts.op == OP_FILL && !sts.fill_last) begin
          cmd.fill_next = 1'b1;
          state_next    = S_LINE_LD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FILL_INIT: begin
        cmd.fill_init = 1'b1;
        src_next      = SRC_COLUMN;
        state_next    = S_FILL_CHK;
      end
      S_FILL_CHK: begin
        state_next = sts.fill_empty ? S_DONE : S_LINE_LD;
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.rd_take = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      src        <= SRC_POINT;
      edge_phase <= 2'd0;
    end else begin
      state      <= state_next;
      src        <= src_next;
      edge_phase <= edge_phase_next;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> state == S_CLEAR)
    else $error("store clear not started after reset");
  a_capture_dispatch: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_DISPATCH)
    else $error("captured word not dispatched");
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_PX_WR |-> $past(state) == S_PX_RD)
    else $error("pixel write without preceding read");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending word");
`endif

endmodule

[rtl/mflrd_dp.sv]
module mflrd_dp #(
  parameter int STORE_BYTES = 32768
) (
  input  logic            clk,
  input  logic            rst,
  input  mflrd_pkg::cmd_t cmd,
  output mflrd_pkg::sts_t sts,
  input  logic [79:0]     s_tdata,
  input  logic [2:0]      s_tuser,
  input  logic [7:0]      w_bytes,
  input  logic [9:0]      h_rows,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata
);
  import mflrd_pkg::*;

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  // captured command
  logic [2:0]         op_q;
  logic [COORD_W-1:0] sx, sy, ex, ey, idx_q;
  logic               ink_q;

  // line engine
  logic signed [CUR_W-1:0] major_cursor, minor_cursor, error_term;
  logic signed [CUR_W-1:0] last_q, dmaj_q, dmin_q, lim_q;
  logic                    steep_q, step_up_q;

  // fill bounds
  logic signed [CUR_W-1:0] fx, fx_end, fy1, fy2;

  // pixel access
  logic [AW-1:0] pix_addr, clr_addr;
  logic [7:0]    pix_mask;
  logic          pix_ok;

  logic [7:0]    result;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic signed [CUR_W-1:0] w_lim, h_lim;

  assign w_lim = $signed({6'd0, w_bytes, 3'd0});
  assign h_lim = $signed({7'd0, h_rows});

  function automatic logic signed [CUR_W-1:0] cz(input logic [COORD_W-1:0] v);
    return $signed({2'b00, v});
  endfunction

  // endpoint select
  logic signed [CUR_W-1:0] x1, y1, x2, y2;
  always_comb begin
    case (cmd.src)
      SRC_FULL:   begin x1 = cz(sx); y1 = cz(sy); x2 = cz(ex); y2 = cz(ey); end
      SRC_EDGE0:  begin x1 = cz(sx); y1 = cz(sy); x2 = cz(sx); y2 = cz(ey); end
      SRC_EDGE1:  begin x1 = cz(sx); y1 = cz(sy); x2 = cz(ex); y2 = cz(sy); end
      SRC_EDGE2:  begin x1 = cz(sx); y1 = cz(ey); x2 = cz(ex); y2 = cz(ey); end
      SRC_EDGE3:  begin x1 = cz(ex); y1 = cz(sy); x2 = cz(ex); y2 = cz(ey); end
      SRC_COLUMN: begin x1 = fx;     y1 = fy1;    x2 = fx;     y2 = fy2;    end
      default:    begin x1 = cz(sx); y1 = cz(sy); x2 = cz(sx); y2 = cz(sy); end
    endcase
  end

  // line setup: pick major axis, order along it
  logic signed [CUR_W-1:0] adx, ady, a1, b1, a2, b2;
  logic                    steep, swap;
  always_comb begin
    adx   = (x2 > x1) ? x2 - x1 : x1 - x2;
    ady   = (y2 > y1) ? y2 - y1 : y1 - y2;
    steep = ady > adx;
    a1    = steep ? y1 : x1;
    b1    = steep ? x1 : y1;
    a2    = steep ? y2 : x2;
    b2    = steep ? x2 : y2;
    swap  = a1 > a2;
  end

  // error update per pixel
  logic signed [CUR_W-1:0] err_dec;
  assign err_dec = error_term - dmin_q;

  // pixel coordinates
  logic signed [CUR_W-1:0] px, py;
  logic [17:0]             addr_sum;
  assign px = steep_q ? minor_cursor : major_cursor;
  assign py = steep_q ? major_cursor : minor_cursor;
  assign addr_sum = 18'(py[9:0]) * 18'(w_bytes) + 18'(px[9:3]);

  // fill corner ordering and clipping
  logic signed [CUR_W-1:0] fxa, fxb, fya, fyb;
  always_comb begin
    fxa = (sx > ex) ? cz(ex) : cz(sx);
    fxb = (sx > ex) ? cz(sx) : cz(ex);
    fya = (sy > ey) ? cz(ey) : cz(sy);
    fyb = (sy > ey) ? cz(sy) : cz(ey);
    if (fxb > w_lim - 17'sd1) fxb = w_lim - 17'sd1;
    if (fyb > h_lim - 17'sd1) fyb = h_lim - 17'sd1;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= s_tuser;
      sx     <= s_tdata[14:0];
      sy     <= s_tdata[29:15];
      ex     <= s_tdata[44:30];
      ey     <= s_tdata[59:45];
      ink_q  <= s_tdata[60];
      idx_q  <= s_tdata[75:61];
      result <= 8'd0;
    end
    if (cmd.line_ld) begin
      steep_q      <= steep;
      major_cursor <= swap ? a2 : a1;
      minor_cursor <= swap ? b2 : b1;
      last_q       <= swap ? a1 : a2;
      step_up_q    <= swap ? (b2 < b1) : (b1 < b2);
      dmaj_q       <= steep ? ady : adx;
      dmin_q       <= steep ? adx : ady;
      error_term   <= (steep ? ady : adx) >>> 1;
      lim_q        <= steep ? h_lim : w_lim;
    end
    if (cmd.px_addr) begin
      pix_ok   <= (px >= 0) && (py >= 0) && (px < w_lim) && (py < h_lim);
      pix_addr <= AW'(addr_sum);
      pix_mask <= PIX_MASK >> px[2:0];
    end
    if (cmd.px_wr) begin
      major_cursor <= major_cursor + 17'sd1;
      if (err_dec < 0) begin
        minor_cursor <= step_up_q ? minor_cursor + 17'sd1 : minor_cursor - 17'sd1;
        error_term   <= err_dec + dmaj_q;
      end else begin
        error_term <= err_dec;
      end
    end
    if (cmd.fill_init) begin
      fx     <= fxa;
      fx_end <= fxb;
      fy1    <= fya;
      fy2    <= fyb;
    end
    if (cmd.fill_next) begin
      fx <= fx + 17'sd1;
    end
    if (cmd.rd_take) begin
      result <= ({17'd0, idx_q} < STORE_BYTES) ? ram_rdata : 8'd0;
    end
    if (cmd.out_load) begin
      m_tdata <= result;
    end
  end

  // clear sweep counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr) clr_addr <= clr_addr + 1'b1;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // frame store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pix_addr;
    ram_wdata = ink_q ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
    ram_raddr = pix_addr;
    if (cmd.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 8'd0;
    end else if (cmd.px_wr) begin
      ram_we = pix_ok;
    end
    if (cmd.rd_issue) ram_raddr = AW'(idx_q);
  end

  mflrd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // status
  always_comb begin
    sts.op         = op_q;
    sts.clr_last   = (clr_addr == AW'(STORE_BYTES - 1));
    sts.run_done   = (major_cursor >= last_q) || (major_cursor + 17'sd1 >= lim_q);
    sts.fill_empty = (fx > fx_end) || (fy1 > fy2);
    sts.fill_last  = (fx == fx_end);
    sts.out_free   = !m_tvalid || m_tready;
  end

endmodule

[rtl/mono_framebuffer_line_rect_drawer_top.sv]
// 1-bit-per-pixel drawing engine with its own frame store (MSB-first bytes,
// rows padded to whole bytes). Commands arrive on the s_ stream: s_tuser is
// the operation (point, line, outline, fill, read byte); s_tdata holds the
// coordinates, ink and byte index. Every command returns exactly one word on
// the m_ stream: the stored byte for a read, zero otherwise.
// Config: cfg_we writes row_width (index 0) or row_count (index 1) from
// cfg_data; write only while no command is in flight.
// Reset: the store is cleared by a sweep of one byte per cycle over all
// ((MAX_WIDTH+7)/8)*MAX_HEIGHT bytes (32768 by default); s_tready stays low
// until it ends. Registers reset to 512 x 512.
// Flow: one command at a time. A read passes dispatch, store read issue and
// data take to done, where its word enters the output register once that is
// free; the next command is taken after that. Each drawn pixel goes through
// address multiply, store read and store write (read-modify-write of its
// byte), after a setup step per line; an outline is four such runs, a fill
// one run per column. Lines stop early once the major axis reaches the frame edge.
// A stalled m_tready holds the result word; the next command is still taken
// and runs, and only its own result waits for the output register.
module mono_framebuffer_line_rect_drawer_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // start_x, start_y, end_x, end_y, ink, byte_index, pad
  input  logic [2:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // read_data
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);
  import mflrd_pkg::*;

  localparam int WB_CAP      = (MAX_WIDTH + 7) / 8;
  localparam int STORE_BYTES = WB_CAP * MAX_HEIGHT;

  localparam logic REG_ROW_WIDTH = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  logic [9:0]  row_width, row_count;
  logic [10:0] wb_raw;
  logic [7:0]  w_bytes;
  logic [9:0]  h_rows;
  cmd_t        cmd;
  sts_t        sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= 10'd512;
      row_count <= 10'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_WIDTH: row_width <= cfg_data;
        REG_ROW_COUNT: row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective geometry: width rounded to bytes and both capped to the store
  assign wb_raw  = (11'(row_width) + 11'd7) >> 3;
  assign w_bytes = (wb_raw > WB_CAP) ? 8'(WB_CAP) : wb_raw[7:0];
  assign h_rows  = (row_count > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : row_count;

  mflrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mflrd_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .w_bytes  (w_bytes),
    .h_rows   (h_rows),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import mflrd_pkg::*;

  localparam int STORE_BYTES = 32768;
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam logic CFG_ROW_WIDTH = 1'b0;
  localparam logic CFG_ROW_COUNT = 1'b1;

  typedef struct {
    logic [2:0]  op;
    logic [14:0] sx, sy, ex, ey;
    logic        ink;
    logic [14:0] byte_idx;
  } draw_cmd_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [79:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [7:0]  m_tdata;
  logic        cfg_we, cfg_index;
  logic [9:0]  cfg_data;

  mono_framebuffer_line_rect_drawer_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // shadow of the frame store and geometry
  logic [7:0]  shadow_fb [0:STORE_BYTES-1];
  int          shadow_width, shadow_rows;
  draw_cmd_t   pending_cmds[$];
  logic [7:0]  expected_bytes[$];
  draw_cmd_t   cur_cmd;
  int          send_idle, recv_idle;
  int          fail_count;
  int          cycle_count;

  function automatic int frame_w();
    int w;
    w = (shadow_width + 7) & ~7;
    return (w > 512) ? 512 : w;
  endfunction

  function automatic int frame_h();
    return (shadow_rows > 512) ? 512 : shadow_rows;
  endfunction

  function automatic void set_pixel(int x, int y, logic ink);
    int w, h, addr;
    w = frame_w();
    h = frame_h();
    if (x < 0 || y < 0 || x >= w || y >= h) return;
    addr = y * (w / 8) + x / 8;
    if (addr >= STORE_BYTES) return;
    if (ink) shadow_fb[addr] = shadow_fb[addr] | (PIX_MASK >> (x % 8));
    else     shadow_fb[addr] = shadow_fb[addr] & ~(PIX_MASK >> (x % 8));
  endfunction

  function automatic void trace_line(int x1, int y1, int x2, int y2, logic ink);
    int t, dx, dy, stp, err, minor, lo, hi, lim, k;
    bit steep, vert;
    if (x1 == x2 && y1 == y2) begin
      set_pixel(x1, y1, ink);
      return;
    end
    // axis-parallel: clipped run
    if (x1 == x2 || y1 == y2) begin
      vert = (x1 == x2);
      lo = vert ? y1 : x1;
      hi = vert ? y2 : x2;
      lim = vert ? frame_h() : frame_w();
      if (lo > hi) begin t = lo; lo = hi; hi = t; end
      if (hi > lim - 1) hi = lim - 1;
      for (k = lo; k <= hi; k++) begin
        if (vert) set_pixel(x1, k, ink);
        else set_pixel(k, y1, ink);
      end
      return;
    end
    // general case: Bresenham, error starts at half the major span
    dx = (x2 > x1) ? x2 - x1 : x1 - x2;
    dy = (y2 > y1) ? y2 - y1 : y1 - y2;
    steep = dy > dx;
    if (steep) begin
      t = x1; x1 = y1; y1 = t;
      t = x2; x2 = y2; y2 = t;
    end
    if (x1 > x2) begin
      t = x1; x1 = x2; x2 = t;
      t = y1; y1 = y2; y2 = t;
    end
    dx = x2 - x1;
    dy = (y2 > y1) ? y2 - y1 : y1 - y2;
    stp = (y1 < y2) ? 1 : -1;
    err = dx / 2;
    minor = y1;
    for (k = x1; k <= x2; k++) begin
      if (steep) set_pixel(minor, k, ink);
      else set_pixel(k, minor, ink);
      err -= dy;
      if (err < 0) begin
        minor += stp;
        err += dx;
      end
    end
  endfunction

  function automatic void fill_box(int x1, int y1, int x2, int y2, logic ink);
    int t, x, y;
    if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
    if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
    if (x2 > frame_w() - 1) x2 = frame_w() - 1;
    if (y2 > frame_h() - 1) y2 = frame_h() - 1;
    for (x = x1; x <= x2; x++)
      for (y = y1; y <= y2; y++)
        set_pixel(x, y, ink);
  endfunction

  // applies one command to the shadow store, returns the result byte
  function automatic logic [7:0] render_cmd(draw_cmd_t c);
    int sx, sy, ex, ey;
    sx = int'(c.sx); sy = int'(c.sy); ex = int'(c.ex); ey = int'(c.ey);
    case (c.op)
      OP_POINT: set_pixel(sx, sy, c.ink);
      OP_LINE:  trace_line(sx, sy, ex, ey, c.ink);
      OP_RECT: begin
        trace_line(sx, sy, sx, ey, c.ink);
        trace_line(sx, sy, ex, sy, c.ink);
        trace_line(sx, ey, ex, ey, c.ink);
        trace_line(ex, sy, ex, ey, c.ink);
      end
      OP_FILL:  fill_box(sx, sy, ex, ey, c.ink);
      OP_READ:  return shadow_fb[c.byte_idx];
      default: ;
    endcase
    return 8'h00;
  endfunction

  function automatic draw_cmd_t mk(logic [2:0] op, int sx, int sy, int ex, int ey,
                                   logic ink, int idx);
    draw_cmd_t c;
    c.op = op; c.sx = 15'(sx); c.sy = 15'(sy); c.ex = 15'(ex); c.ey = 15'(ey);
    c.ink = ink; c.byte_idx = 15'(idx);
    return c;
  endfunction

  function automatic int coord(int span);
    return ($urandom_range(99) < 6) ? $urandom_range(32767) : $urandom_range(span);
  endfunction

  // random commands; wide fills only where the frame is small
  task automatic queue_random(int n, int span, bit wide_ok);
    int i, pick, fspan;
    logic [2:0] op;
    fspan = wide_ok ? span : ((span < 40) ? span : 40);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 22) op = OP_POINT;
      else if (pick < 47) op = OP_LINE;
      else if (pick < 60) op = OP_RECT;
      else if (pick < 70) op = OP_FILL;
      else if (pick < 95) op = OP_READ;
      else op = 3'($urandom_range(OP_READ + 1, 7));
      case (op)
        OP_LINE:
          pending_cmds.push_back(mk(op, $urandom_range(span), $urandom_range(span),
            $urandom_range(span), $urandom_range(span), 1'($urandom), $urandom));
        OP_FILL:
          if (wide_ok)
            pending_cmds.push_back(mk(op, coord(fspan), coord(fspan), coord(fspan),
              coord(fspan), 1'($urandom), $urandom));
          else
            pending_cmds.push_back(mk(op, $urandom_range(fspan), $urandom_range(fspan),
              $urandom_range(fspan), $urandom_range(fspan), 1'($urandom), $urandom));
        OP_READ:
          pending_cmds.push_back(mk(op, $urandom, $urandom, $urandom, $urandom,
            1'($urandom),
            ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(2047)));
        default:
          pending_cmds.push_back(mk(op, coord(span), coord(span), coord(span),
            coord(span), 1'($urandom), $urandom));
      endcase
    end
  endtask

  // wait until the block is idle with nothing outstanding
  task automatic drain();
    while (pending_cmds.size() != 0 || s_tvalid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_ROW_WIDTH) shadow_width = int'(val);
    else shadow_rows = int'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(logic [9:0] w, logic [9:0] h);
    write_reg(CFG_ROW_WIDTH, w);
    write_reg(CFG_ROW_COUNT, h);
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_bytes.push_back(render_cmd(cur_cmd));
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_cmd = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_cmd.op;
          s_tdata <= {4'b0, cur_cmd.byte_idx, cur_cmd.ink, cur_cmd.ey, cur_cmd.ex,
                      cur_cmd.sy, cur_cmd.sx};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected word: read_data %0h", m_tdata);
          fail_count++;
        end else begin
          if (m_tdata !== expected_bytes[0]) begin
            $error("read_data mismatch: expected %0h actual %0h", expected_bytes[0], m_tdata);
            fail_count++;
          end
          void'(expected_bytes.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_POINT;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ROW_WIDTH;
    cfg_data = '0;
    fail_count = 0;
    cycle_count = 0;
    shadow_width = 512;
    shadow_rows = 512;
    send_idle = 20;
    recv_idle = 50;
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: corners, clipping, every operation and odd shapes
    pending_cmds.push_back(mk(OP_POINT, 0, 0, 0, 0, 1'b1, 0));
    pending_cmds.push_back(mk(OP_POINT, 511, 511, 0, 0, 1'b1, 0));
    pending_cmds.push_back(mk(OP_POINT, 512, 0, 0, 0, 1'b1, 0));
    pending_cmds.push_back(mk(OP_POINT, 32767, 32767, 32767, 32767, 1'b1, 32767));
    pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 0, 1'b0, 0));
    pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 0, 1'b0, 32767));
    pending_cmds.push_back(mk(OP_LINE, 0, 5, 40, 5, 1'b1, 0));
    pending_cmds.push_back(mk(OP_LINE, 3, 30, 3, 2, 1'b1, 0));
    pending_cmds.push_back(mk(OP_LINE, 10, 10, 14, 40, 1'b1, 0));
    pending_cmds.push_back(mk(OP_LINE, 50, 20, 10, 10, 1'b1, 0));
    pending_cmds.push_back(mk(OP_LINE, 7, 7, 7, 7, 1'b1, 0));
    pending_cmds.push_back(mk(OP_LINE, 500, 3, 600, 3, 1'b1, 0));
    pending_cmds.push_back(mk(OP_RECT, 30, 30, 20, 25, 1'b1, 0));
    pending_cmds.push_back(mk(OP_FILL, 60, 10, 50, 4, 1'b1, 0));
    pending_cmds.push_back(mk(OP_FILL, 58, 8, 52, 6, 1'b0, 0));
    pending_cmds.push_back(mk(OP_POINT, 3, 5, 0, 0, 1'b0, 0));
    pending_cmds.push_back(mk(3'd5, 1, 1, 2, 2, 1'b1, 0));
    pending_cmds.push_back(mk(3'd7, 1, 1, 2, 2, 1'b1, 0));
    pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 0, 1'b0, 320));
    pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 0, 1'b0, 448));
    pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 0, 1'b0, 457));
    pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 0, 1'b0, 32767 - 0));
    pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 0, 1'b0, 32767 - 1));
    pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 0, 1'b0, 511 * 64 + 63));
    queue_random(150, 100, 1'b0);
    drain();

    // smallest frame
    set_frame(10'd8, 10'd1);
    queue_random(60, 20, 1'b1);
    drain();

    // zero width, height past the store
    set_frame(10'd0, 10'd1023);
    queue_random(30, 60, 1'b0);
    drain();

    // width past the store, zero height
    set_frame(10'd1023, 10'd0);
    queue_random(30, 60, 1'b0);
    drain();

    // odd width rounded up to 16
    send_idle = 50;
    recv_idle = 20;
    set_frame(10'd13, 10'd37);
    queue_random(120, 40, 1'b1);
    drain();

    // full frame, no idling
    send_idle = 0;
    recv_idle = 0;
    set_frame(10'd512, 10'd512);
    queue_random(150, 200, 1'b0);
    drain();

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
rtl/mflrd_pkg.sv
rtl/mflrd_ram.sv
rtl/mflrd_ctrl.sv
rtl/mflrd_dp.sv
rtl/mono_framebuffer_line_rect_drawer_top.sv
sim/testbench.sv
